[rtl/core/byte_fifo_soft_limit_core_macros.svh]
// Assertion macros for the byte FIFO core.
`ifndef BYTE_FIFO_SOFT_LIMIT_CORE_MACROS_SVH
`define BYTE_FIFO_SOFT_LIMIT_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define BFSL_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bfsl assertion failed");
`define BFSL_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("bfsl forbidden condition seen");
`else
`define BFSL_ASSERT(lbl, clk, rst, prop)
`define BFSL_ASSERT_NEVER(lbl, clk, rst, cond)
`endif

`endif

[rtl/core/bfsl_pkg.sv]
`timescale 1ns / 1ps

package bfsl_pkg;

   localparam int DEPTH       = 1024;
   localparam int MAX_READ    = 64;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int IDX_W       = ADDR_W + 1;
   localparam int BYTE_W      = 8;
   localparam int LIMIT_W     = 11;
   localparam int FILL_W      = 11;
   localparam int CNT_W       = 7;
   localparam int CMP_W       = (IDX_W > LIMIT_W) ? IDX_W : LIMIT_W;
   localparam int LIMIT_RESET = 1024;

   localparam int REQ_DATA_W  = 16;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 24;
   localparam int RSP_USER_W  = 2;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_READ  = 1'b1
   } op_type;

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   typedef struct packed {
      logic wr;
      logic empty;
      logic rd_issue;
      logic rd_last;
      logic rd_push;
   } cmd_type;

   typedef struct packed {
      logic [1:0]       q_cnt;
      logic             pop;
      logic [CNT_W-1:0] rd_n;
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] rd_byte;
      logic              rd_valid;
      logic              wr_accepted;
      logic [FILL_W-1:0] fill;
      logic              last;
   } result_type;

endpackage

[rtl/core/byte_fifo_soft_limit_core.sv]
`timescale 1ns / 1ps
`include "byte_fifo_soft_limit_core_macros.svh"

// Byte FIFO over a 1024-byte single-port-write, registered-read RAM. A write word
// (tuser op = 0) returns one response word; a burst is refused whole if the fill
// level at its first byte already reaches soft_limit, otherwise bytes are stored
// until the RAM is full. A read word (op = 1) returns min(rd_count, 64, fill level)
// bytes, one per cycle while the output queue has room, the last one with tlast
// set, or one word with rd_valid low when nothing can be read. A read holds the
// request side, one RAM read per byte, until its last byte has left the RAM read
// stage; writes and empty reads sustain one word per cycle while there is room.
// A two-word output queue lets a request be taken while one response word waits.
// The RAM contents are not cleared at reset, and no clearing pass is needed.
module byte_fifo_soft_limit_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bfsl_pkg::REQ_DATA_W-1:0]   req_tdata,   // wr_byte[7:0], rd_count[14:8]
   input  logic [bfsl_pkg::REQ_USER_W-1:0]   req_tuser,   // op[0], burst_start[1]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bfsl_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // rd_byte[7:0], fill_level[18:8]
   output logic [bfsl_pkg::RSP_USER_W-1:0]   rsp_tuser,   // rd_valid[0], wr_accepted[1]
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [bfsl_pkg::LIMIT_W-1:0]      csr_wdata    // soft_limit
);
   import bfsl_pkg::*;

   cmd_type    cmd;
   status_type status;
   result_type result;
   op_type     req_op;

   assign req_op = op_type'(req_tuser[0]);

   bfsl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_op),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bfsl_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .burst_start (req_tuser[1]),
      .wr_byte     (req_tdata[BYTE_W-1:0]),
      .rd_count    (req_tdata[BYTE_W+CNT_W-1:BYTE_W]),
      .cmd         (cmd),
      .status      (status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .result      (result)
   );

   assign rsp_tdata = {{(RSP_DATA_W-BYTE_W-FILL_W){1'b0}}, result.fill, result.rd_byte};
   assign rsp_tuser = {result.wr_accepted, result.rd_valid};
   assign rsp_tlast = result.last;

   `BFSL_ASSERT(a_issue_then_push, clock, reset, (cmd.rd_issue |=> cmd.rd_push))
   `BFSL_ASSERT(a_single_push, clock, reset, $onehot0({cmd.wr, cmd.empty, cmd.rd_push}))
   `BFSL_ASSERT_NEVER(a_queue_overflow, clock, reset, ((status.q_cnt == 2'd2) && !status.pop && (cmd.wr || cmd.empty || cmd.rd_push)))
   `BFSL_ASSERT(a_fill_bound, clock, reset, (rsp_tvalid |-> (CMP_W'(result.fill) <= CMP_W'(DEPTH))))

endmodule

[rtl/core/bfsl_ram.sv]
`timescale 1ns / 1ps

module bfsl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/bfsl_ctrl.sv]
`timescale 1ns / 1ps

module bfsl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  bfsl_pkg::op_type     req_op,
   output logic                 req_tready,
   input  bfsl_pkg::status_type status,
   output bfsl_pkg::cmd_type    cmd
);
   import bfsl_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] remain_ff, remain_in;
   logic             pend_ff, pend_in;
   logic             room;
   logic             credit;
   logic             fire;

   // room: queue takes a push this cycle; credit: also counts the word in the RAM read stage
   assign room   = (status.q_cnt != 2'd2) || status.pop;
   assign credit = ({1'b0, status.q_cnt} + {2'b00, pend_ff}) <= (3'd1 + {2'b00, status.pop});
   assign fire   = req_tvalid && req_tready;

   always_comb begin
      req_tready   = 1'b0;
      cmd          = '0;
      cmd.rd_push  = pend_ff;
      case (state_ff)
         S_IDLE: begin
            req_tready = room && !pend_ff;
            cmd.wr     = req_tvalid && req_tready && (req_op == OP_WRITE);
            cmd.empty  = req_tvalid && req_tready && (req_op == OP_READ) &&
                         (status.rd_n == '0);
         end
         S_READ: begin
            cmd.rd_issue = credit;
            cmd.rd_last  = (remain_ff == CNT_W'(1));
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      remain_in = remain_ff;
      pend_in   = cmd.rd_issue;
      case (state_ff)
         S_IDLE: begin
            if (fire && (req_op == OP_READ) && (status.rd_n != '0)) begin
               state_in  = S_READ;
               remain_in = status.rd_n;
            end
         end
         S_READ: begin
            if (cmd.rd_issue) begin
               remain_in = remain_ff - CNT_W'(1);
               if (remain_ff == CNT_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         remain_ff <= '0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         remain_ff <= remain_in;
         pend_ff   <= pend_in;
      end
   end

endmodule

[rtl/core/bfsl_datapath.sv]
`timescale 1ns / 1ps

module bfsl_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [bfsl_pkg::LIMIT_W-1:0]   csr_wdata,
   input  logic                           burst_start,
   input  logic [bfsl_pkg::BYTE_W-1:0]    wr_byte,
   input  logic [bfsl_pkg::CNT_W-1:0]     rd_count,
   input  bfsl_pkg::cmd_type              cmd,
   output bfsl_pkg::status_type           status,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output bfsl_pkg::result_type           result
);
   import bfsl_pkg::*;

   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [IDX_W-1:0]   wi_ff, wi_in;
   logic [IDX_W-1:0]   ri_ff, ri_in;
   logic               open_ff, open_in;
   logic [FILL_W-1:0]  stage_fill_ff, stage_fill_in;
   logic               stage_last_ff, stage_last_in;
   result_type         q_ff [2];
   logic               head_ff, head_in;
   logic [1:0]         cnt_ff, cnt_in;

   logic [IDX_W-1:0]   used_full;
   logic [IDX_W-1:0]   ri_next;
   logic [CMP_W-1:0]   used_c;
   logic               below_limit;
   logic               not_full;
   logic               open_eff;
   logic               store;
   logic [CNT_W-1:0]   sat;
   logic [CNT_W-1:0]   rd_n;
   logic [BYTE_W-1:0]  ram_q;
   logic               push;
   logic               pop;
   logic               tail;
   result_type         push_data;

   assign used_full   = wi_ff - ri_ff;
   assign ri_next     = ri_ff + IDX_W'(1);
   assign used_c      = CMP_W'(used_full);
   assign below_limit = used_c < CMP_W'(limit_ff);
   assign not_full    = used_c < CMP_W'(DEPTH);
   assign open_eff    = burst_start ? below_limit : open_ff;
   assign store       = cmd.wr && open_eff && not_full;

   assign sat  = (rd_count > CNT_W'(MAX_READ)) ? CNT_W'(MAX_READ) : rd_count;
   assign rd_n = (used_c < CMP_W'(sat)) ? CNT_W'(used_c) : sat;

   always_comb begin
      limit_in      = csr_we ? csr_wdata : limit_ff;
      wi_in         = store ? (wi_ff + IDX_W'(1)) : wi_ff;
      ri_in         = cmd.rd_issue ? ri_next : ri_ff;
      open_in       = (cmd.wr && burst_start) ? below_limit : open_ff;
      stage_fill_in = cmd.rd_issue ? FILL_W'(wi_ff - ri_next) : stage_fill_ff;
      stage_last_in = cmd.rd_issue ? cmd.rd_last : stage_last_ff;
   end

   bfsl_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (store),
      .waddr (wi_ff[ADDR_W-1:0]),
      .wdata (wr_byte),
      .re    (cmd.rd_issue),
      .raddr (ri_ff[ADDR_W-1:0]),
      .rdata (ram_q)
   );

   // result word for whichever source pushes this cycle
   always_comb begin
      push_data = '0;
      if (cmd.wr) begin
         push_data.wr_accepted = store;
         push_data.fill        = FILL_W'(used_full + IDX_W'(store));
         push_data.last        = 1'b1;
      end else if (cmd.empty) begin
         push_data.fill = FILL_W'(used_full);
         push_data.last = 1'b1;
      end else if (cmd.rd_push) begin
         push_data.rd_byte  = ram_q;
         push_data.rd_valid = 1'b1;
         push_data.fill     = stage_fill_ff;
         push_data.last     = stage_last_ff;
      end
   end

   // two-word output queue
   assign push    = cmd.wr || cmd.empty || cmd.rd_push;
   assign pop     = (cnt_ff != 2'd0) && rsp_tready;
   assign tail    = head_ff ^ cnt_ff[0];
   assign head_in = pop ? !head_ff : head_ff;
   assign cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[tail] <= push_data;
      end
      stage_fill_ff <= stage_fill_in;
      stage_last_ff <= stage_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_W'(LIMIT_RESET);
         wi_ff    <= '0;
         ri_ff    <= '0;
         open_ff  <= 1'b0;
         head_ff  <= 1'b0;
         cnt_ff   <= 2'd0;
      end else begin
         limit_ff <= limit_in;
         wi_ff    <= wi_in;
         ri_ff    <= ri_in;
         open_ff  <= open_in;
         head_ff  <= head_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign rsp_tvalid   = cnt_ff != 2'd0;
   assign result       = q_ff[head_ff];
   assign status.q_cnt = cnt_ff;
   assign status.pop   = pop;
   assign status.rd_n  = rd_n;

endmodule
